[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset
`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication
`define ASSERT_IMPLY(name, cond, conseq, msg) \
    `ASSERT_CLK(name, (cond) |-> (conseq), msg)

`endif

[rtl/cker_pkg.sv]
// ----------------------------------------------------------------------------
// cker_pkg
// Shared types, constants and helpers of the color key run-length encoder.
// ----------------------------------------------------------------------------
package cker_pkg;

    // Longest run before it is forced closed
    localparam int MAX_RUN_DEF = 126;

    // Run length field, fixed by the 7-bit count in the coded byte
    localparam int LEN_W = 7;

    // Command queue depth between front and back
    localparam int FIFO_DEPTH = 4;

    // Configuration register indexes
    localparam logic [0:0] CFG_KEY_ENABLE = 1'b0;
    localparam logic [0:0] CFG_KEY_VALUE  = 1'b1;

    // Kind of the open run
    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_LIT   = 2'd1,
        MODE_TRANS = 2'd2
    } mode_t;

    // Back-end byte sequencer states
    typedef enum logic [0:0] {
        SEQ_HDR  = 1'b0,
        SEQ_DATA = 1'b1
    } seq_state_t;

    // One closed run to be coded
    typedef struct packed {
        logic             is_lit;
        logic             bank;
        logic [LEN_W-1:0] len;
        logic             last;    // final run coded for its pixel
    } cmd_t;

    // Up to two closed runs per accepted pixel, older one first
    typedef struct packed {
        logic valid0;
        cmd_t cmd0;
        logic valid1;
        cmd_t cmd1;
    } cmd_push_t;

    // Literal buffer bank handed back by the back end
    typedef struct packed {
        logic valid;
        logic bank;
    } bank_rel_t;

    // Index bits needed for one bank of the literal buffer
    function automatic int idx_width(input int max_run);
        return (max_run > 1) ? $clog2(max_run) : 1;
    endfunction

endpackage

[rtl/cker_ram.sv]
// ----------------------------------------------------------------------------
// cker_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module cker_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/cker_front.sv]
// ----------------------------------------------------------------------------
// cker_front
// Accepts pixels, classifies them against the key, tracks the open run,
// buffers literal pixels and queues one command per closed run.
// ----------------------------------------------------------------------------
module cker_front #(
    parameter int MAX_RUN = cker_pkg::MAX_RUN_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 pix_valid,
    output logic                                 pix_stall,
    input  logic [7:0]                           pixel,
    input  logic                                 row_end,
    input  logic                                 cfg_we,
    input  logic [0:0]                           cfg_index,
    input  logic [7:0]                           cfg_data,
    input  logic                                 space2,
    output cker_pkg::cmd_push_t                  push,
    input  cker_pkg::bank_rel_t                  rel,
    output logic                                 wr_en,
    output logic [cker_pkg::idx_width(MAX_RUN):0] wr_addr,
    output logic [7:0]                           wr_data
);
    import cker_pkg::*;

    localparam int IDX_W = idx_width(MAX_RUN);

    logic             key_en_reg, key_en_next;
    logic [7:0]       key_val_reg, key_val_next;
    mode_t            mode_reg, mode_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             bank_reg, bank_next;
    logic [1:0]       busy_reg, busy_next;

    logic             kind_lit;
    mode_t            kind;
    logic             close_old;
    logic             old_lit;
    logic             new_bank;
    logic [LEN_W-1:0] new_len;
    logic [LEN_W-1:0] wr_idx;
    logic             close_new;
    logic             bank_block;
    logic             accept;

    // Classify the pixel and work out what it does to the open run
    always_comb
    begin
        kind_lit   = !(key_en_reg && (pixel == key_val_reg));
        kind       = kind_lit ? MODE_LIT : MODE_TRANS;
        close_old  = (mode_reg != MODE_NONE) && (mode_reg != kind);
        old_lit    = (mode_reg == MODE_LIT);
        new_bank   = bank_reg ^ (close_old && old_lit);
        new_len    = close_old ? LEN_W'(1) : len_reg + LEN_W'(1);
        wr_idx     = close_old ? '0 : len_reg;
        close_new  = row_end || (new_len >= LEN_W'(MAX_RUN));
        // a new literal run needs its bank drained first
        bank_block = kind_lit && (mode_reg != MODE_LIT) && busy_reg[bank_reg];
        pix_stall  = !space2 || bank_block;
        accept     = pix_valid && !pix_stall;
    end

    // Literal pixel into the buffer
    always_comb
    begin
        wr_en   = accept && kind_lit;
        wr_addr = {new_bank, wr_idx[IDX_W-1:0]};
        wr_data = pixel;
    end

    // Commands for the runs this pixel closes
    always_comb
    begin
        push.valid0      = accept && close_old;
        push.cmd0.is_lit = old_lit;
        push.cmd0.bank   = bank_reg;
        push.cmd0.len    = len_reg;
        push.cmd0.last   = !close_new;
        push.valid1      = accept && close_new;
        push.cmd1.is_lit = kind_lit;
        push.cmd1.bank   = new_bank;
        push.cmd1.len    = new_len;
        push.cmd1.last   = 1'b1;
    end

    // Run state, bank tracking and configuration
    always_comb
    begin
        key_en_next  = key_en_reg;
        key_val_next = key_val_reg;
        mode_next    = mode_reg;
        len_next     = len_reg;
        bank_next    = bank_reg;
        busy_next    = busy_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KEY_ENABLE: key_en_next  = cfg_data[0];
                CFG_KEY_VALUE:  key_val_next = cfg_data;
                default:        key_en_next  = key_en_reg;
            endcase
        end

        if (rel.valid)
        begin
            busy_next[rel.bank] = 1'b0;
        end

        if (accept)
        begin
            if (close_old && old_lit)
            begin
                busy_next[bank_reg] = 1'b1;
            end
            if (close_new && kind_lit)
            begin
                busy_next[new_bank] = 1'b1;
            end
            bank_next = new_bank ^ (close_new && kind_lit);
            if (close_new)
            begin
                mode_next = MODE_NONE;
                len_next  = '0;
            end
            else
            begin
                mode_next = kind;
                len_next  = new_len;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_en_reg  <= 1'b0;
            key_val_reg <= 8'd0;
            mode_reg    <= MODE_NONE;
            len_reg     <= '0;
            bank_reg    <= 1'b0;
            busy_reg    <= '0;
        end
        else
        begin
            key_en_reg  <= key_en_next;
            key_val_reg <= key_val_next;
            mode_reg    <= mode_next;
            len_reg     <= len_next;
            bank_reg    <= bank_next;
            busy_reg    <= busy_next;
        end
    end

endmodule

[rtl/cker_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// cker_cmd_fifo
// Short command queue between front and back; two pushes, one pop a cycle.
// ----------------------------------------------------------------------------
module cker_cmd_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  cker_pkg::cmd_push_t push,
    input  logic                pop,
    output cker_pkg::cmd_t      head,
    output logic                empty,
    output logic                space2
);
    import cker_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    cmd_t             entry_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] wr_ptr1;
    logic [CNT_W-1:0] n_push;
    logic             do_pop;

    // Pointer and fill bookkeeping
    always_comb
    begin
        do_pop      = pop && (count_reg != '0);
        n_push      = CNT_W'(push.valid0) + CNT_W'(push.valid1);
        wr_ptr1     = wr_ptr_reg + PTR_W'(push.valid0);
        wr_ptr_next = wr_ptr_reg + n_push[PTR_W-1:0];
        rd_ptr_next = rd_ptr_reg + PTR_W'(do_pop);
        count_next  = count_reg + n_push - CNT_W'(do_pop);
        empty       = (count_reg == '0);
        space2      = (count_reg <= CNT_W'(FIFO_DEPTH - 2));
        head        = entry_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, older command lands first
    always_ff @(posedge clk)
    begin
        if (push.valid0)
        begin
            entry_reg[wr_ptr_reg] <= push.cmd0;
        end
        if (push.valid1)
        begin
            entry_reg[wr_ptr1] <= push.cmd1;
        end
    end

endmodule

[rtl/cker_back.sv]
// ----------------------------------------------------------------------------
// cker_back
// Turns queued runs into coded bytes, one a cycle unless the result stalls,
// and packs them four to a result word behind an output register.
// ----------------------------------------------------------------------------
module cker_back #(
    parameter int MAX_RUN = cker_pkg::MAX_RUN_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  cker_pkg::cmd_t                        head,
    input  logic                                  empty,
    output logic                                  pop,
    output cker_pkg::bank_rel_t                   rel,
    output logic                                  rd_en,
    output logic [cker_pkg::idx_width(MAX_RUN):0] rd_addr,
    input  logic [7:0]                            rd_data,
    output logic                                  res_valid,
    input  logic                                  res_stall,
    output logic [31:0]                           code_bytes,
    output logic [2:0]                            byte_count,
    output logic                                  burst_last
);
    import cker_pkg::*;

    localparam int IDX_W = idx_width(MAX_RUN);

    seq_state_t       state_reg, state_next;
    logic [LEN_W-1:0] idx_reg, idx_next;

    // byte stage (registered alongside the RAM read data)
    logic             s1_valid_reg;
    logic             s1_ram_reg;
    logic [7:0]       s1_hdr_reg;
    logic             s1_end_reg;

    // packing accumulator and output register
    logic [23:0]      acc_reg, acc_next;
    logic [1:0]       acc_cnt_reg, acc_cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic [31:0]      out_word_reg;
    logic [2:0]       out_cnt_reg;
    logic             out_last_reg;

    logic             issue;
    logic             issue_ram;
    logic             issue_end;
    logic [7:0]       issue_hdr;
    logic             idx_last;
    logic             adv;
    logic             out_free;
    logic             word_done;
    logic             s1_take;
    logic [7:0]       s1_byte;
    logic [31:0]      word_full;

    // Packer handshake
    always_comb
    begin
        out_free  = !out_valid_reg || !res_stall;
        word_done = (acc_cnt_reg == 2'd3) || s1_end_reg;
        s1_take   = s1_valid_reg && (!word_done || out_free);
        adv       = !s1_valid_reg || s1_take;
        idx_last  = (idx_reg == head.len - LEN_W'(1));
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SEQ_HDR:
            begin
                if (!empty && adv && head.is_lit)
                begin
                    state_next = SEQ_DATA;
                end
            end
            SEQ_DATA:
            begin
                if (adv && idx_last)
                begin
                    state_next = SEQ_HDR;
                end
            end
            default: state_next = SEQ_HDR;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        issue     = 1'b0;
        issue_ram = 1'b0;
        issue_end = 1'b0;
        issue_hdr = {!head.is_lit, head.len};
        pop       = 1'b0;
        rel.valid = 1'b0;
        rel.bank  = head.bank;
        idx_next  = idx_reg;
        unique case (state_reg)
            SEQ_HDR:
            begin
                if (!empty && adv)
                begin
                    issue     = 1'b1;
                    issue_end = head.last && !head.is_lit;
                    pop       = !head.is_lit;
                    idx_next  = '0;
                end
            end
            SEQ_DATA:
            begin
                if (adv)
                begin
                    issue     = 1'b1;
                    issue_ram = 1'b1;
                    issue_end = head.last && idx_last;
                    pop       = idx_last;
                    rel.valid = idx_last;
                    idx_next  = idx_reg + LEN_W'(1);
                end
            end
            default: issue = 1'b0;
        endcase
    end

    assign rd_en   = issue_ram;
    assign rd_addr = {head.bank, idx_reg[IDX_W-1:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= SEQ_HDR;
            idx_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (adv)
            begin
                s1_valid_reg <= issue;
            end
        end
    end

    // Byte stage payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ram_reg <= issue_ram;
            s1_hdr_reg <= issue_hdr;
            s1_end_reg <= issue_end;
        end
    end

    // Insert the byte into the accumulator
    always_comb
    begin
        s1_byte        = s1_ram_reg ? rd_data : s1_hdr_reg;
        word_full      = {8'd0, acc_reg} | ({24'd0, s1_byte} << {acc_cnt_reg, 3'b000});
        acc_next       = acc_reg;
        acc_cnt_next   = acc_cnt_reg;
        out_valid_next = out_valid_reg && res_stall;
        if (s1_take)
        begin
            if (word_done)
            begin
                acc_next       = '0;
                acc_cnt_next   = '0;
                out_valid_next = 1'b1;
            end
            else
            begin
                acc_next     = word_full[23:0];
                acc_cnt_next = acc_cnt_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            acc_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            acc_cnt_reg   <= acc_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output word register
    always_ff @(posedge clk)
    begin
        if (s1_take && word_done)
        begin
            out_word_reg <= word_full;
            out_cnt_reg  <= {1'b0, acc_cnt_reg} + 3'd1;
            out_last_reg <= s1_end_reg;
        end
    end

    assign res_valid  = out_valid_reg;
    assign code_bytes = out_word_reg;
    assign byte_count = out_cnt_reg;
    assign burst_last = out_last_reg;

endmodule

[rtl/color_key_rle_encoder.sv]
// ----------------------------------------------------------------------------
// color_key_rle_encoder
// Run-length coder for 8-bit pixel rows with a transparent color key.
// ----------------------------------------------------------------------------
// Usage:
//   Pixel channel (pix_valid/pix_stall, pixel, row_end) takes one pixel per
//   transaction. Result channel (res_valid/res_stall) delivers words of up to
//   four coded bytes, first byte in bits 7..0, with byte_count and burst_last
//   marking the final word caused by one pixel. Config channel
//   (cfg_valid/cfg_ready, always ready) writes key_enable (index 0) and
//   key_value (index 1); write only while the block is idle.
//   Throughput: one pixel per cycle while runs are only extended. The back
//   end emits one coded byte per cycle unless the result is stalled, so a
//   closed literal run of n pixels occupies it for a header byte and n data
//   bytes; the front stalls when the 4-entry command queue has fewer than
//   two free slots or a new literal run needs a buffer bank still being
//   read out (two banks). Each queued run is sequenced into bytes, which pass
//   through the byte stage and are packed into the registered result word.
//   Reset clears run state, key registers and all valid flags; the literal
//   buffer needs no clearing. A stalled result holds and back-pressures the
//   byte sequencer, then the queue, then the pixel channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module color_key_rle_encoder #(
    parameter int MAX_RUN = cker_pkg::MAX_RUN_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pix_valid,
    output logic        pix_stall,
    input  logic [7:0]  pixel,
    input  logic        row_end,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [31:0] code_bytes,
    output logic [2:0]  byte_count,
    output logic        burst_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import cker_pkg::*;

    localparam int IDX_W  = idx_width(MAX_RUN);
    localparam int ADDR_W = IDX_W + 1;

    cmd_push_t         push;
    bank_rel_t         rel;
    cmd_t              head;
    logic              fifo_empty;
    logic              fifo_space2;
    logic              fifo_pop;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;
    logic              cfg_we;

    // Config writes are taken in any cycle
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    cker_front #(
        .MAX_RUN (MAX_RUN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pixel     (pixel),
        .row_end   (row_end),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .space2    (fifo_space2),
        .push      (push),
        .rel       (rel),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    cker_cmd_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (fifo_pop),
        .head   (head),
        .empty  (fifo_empty),
        .space2 (fifo_space2)
    );

    // Two banks of literal pixels
    cker_ram #(
        .WIDTH (8),
        .DEPTH (2 << IDX_W)
    ) u_lit_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    cker_back #(
        .MAX_RUN (MAX_RUN)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .empty      (fifo_empty),
        .pop        (fifo_pop),
        .rel        (rel),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .code_bytes (code_bytes),
        .byte_count (byte_count),
        .burst_last (burst_last)
    );

    // Checks
    `ASSERT_IMPLY(a_count_range, res_valid, (byte_count != 3'd0) && (byte_count <= 3'd4), "bad count")
    `ASSERT_IMPLY(a_single_zero, res_valid && (byte_count == 3'd1), code_bytes[31:8] == 24'd0, "upper bytes set")
    `ASSERT_IMPLY(a_queue_guard, !fifo_space2, pix_stall, "pixel taken without queue room")

endmodule

[verif/color_key_rle_encoder_tb.sv]
// ----------------------------------------------------------------------------
// color_key_rle_encoder_tb
// Self-checking bench for the color key run-length encoder. A queue of pixel
// transactions feeds a clocked driver; a clocked monitor predicts the coded
// words of every accepted pixel and checks each result word against them.
// ----------------------------------------------------------------------------
module color_key_rle_encoder_tb;
    import cker_pkg::*;

    localparam int RUN_LIMIT    = MAX_RUN_DEF;
    localparam int STUCK_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 400;

    typedef struct {
        logic [7:0] px;
        logic       re;
    } pix_item_t;

    typedef struct {
        logic [31:0] data;
        logic [2:0]  count;
        logic        last;
    } code_word_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        pix_valid;
    logic        pix_stall;
    logic [7:0]  pixel;
    logic        row_end;
    logic        res_valid;
    logic        res_stall;
    logic [31:0] code_bytes;
    logic [2:0]  byte_count;
    logic        burst_last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [7:0]  cfg_data;

    // Stimulus side
    pix_item_t   pix_q[$];
    int          src_idle_pct;
    int          rcv_stall_pct;
    logic        rcv_hold;
    logic        hold_go = 1'b0;
    logic        pix_fire;
    logic        stim_key_en;
    logic [7:0]  stim_key;

    // Encoder shadow state
    logic             key_en;
    logic [7:0]       key_val;
    mode_t            run_kind;
    logic [LEN_W-1:0] run_len;
    logic [7:0]       lit_buf [0:127];
    logic [7:0]       code_q[$];
    code_word_t       exp_words[$];

    int errors;
    int n_pixels;
    int n_words;
    int n_bursts;
    int n_cfg;

    color_key_rle_encoder u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_valid  (pix_valid),
        .pix_stall  (pix_stall),
        .pixel      (pixel),
        .row_end    (row_end),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .code_bytes (code_bytes),
        .byte_count (byte_count),
        .burst_last (burst_last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Emit the code bytes of the open run and close it
    function automatic void close_run();
        int k;
        if (run_kind == MODE_TRANS)
        begin
            code_q.push_back(8'h80 | {1'b0, run_len});
        end
        else if (run_kind == MODE_LIT)
        begin
            code_q.push_back({1'b0, run_len});
            for (k = 0; k < run_len; k++)
                code_q.push_back(lit_buf[k]);
        end
        run_kind = MODE_NONE;
        run_len  = '0;
    endfunction

    // Coded words caused by one accepted pixel, appended to exp_words
    function automatic void encode_pixel(input logic [7:0] px, input logic re);
        mode_t      kind;
        code_word_t w;
        int         pos;
        int         n;
        int         k;
        kind = (key_en && px == key_val) ? MODE_TRANS : MODE_LIT;
        code_q.delete();
        // a kind change closes the open run before this pixel joins
        if (run_kind != MODE_NONE && run_kind != kind)
            close_run();
        if (kind == MODE_LIT)
            lit_buf[run_len] = px;
        run_kind = kind;
        run_len  = run_len + 1'b1;
        if (re || run_len >= RUN_LIMIT)
            close_run();
        // pack four bytes per word, earliest byte lowest
        for (pos = 0; pos < code_q.size(); pos += 4)
        begin
            n = code_q.size() - pos;
            if (n > 4)
                n = 4;
            w.data = '0;
            for (k = 0; k < n; k++)
                w.data[8*k +: 8] = code_q[pos + k];
            w.count = 3'(n);
            w.last  = (pos + 4 >= code_q.size());
            exp_words.push_back(w);
        end
    endfunction

    function automatic void push_pixel(input logic [7:0] px, input logic re);
        pix_item_t item;
        item.px = px;
        item.re = re;
        pix_q.push_back(item);
    endfunction

    // Random pixel that is never the active key
    function automatic logic [7:0] pick_literal();
        logic [7:0] px;
        px = 8'($urandom);
        if (stim_key_en && px == stim_key)
            px = px ^ 8'h01;
        return px;
    endfunction

    // Optional long run through the run limit, then short rows of mixed runs
    // with some raw noise transactions
    task automatic queue_random(input int budget, input mode_t long_kind);
        int   added;
        int   row_len;
        int   seg;
        int   i;
        int   j;
        logic trans;
        added = 0;
        if (long_kind != MODE_NONE)
        begin
            row_len = $urandom_range(RUN_LIMIT + 14, RUN_LIMIT);
            for (i = 0; i < row_len; i++)
                push_pixel((long_kind == MODE_TRANS) ? stim_key : pick_literal(),
                           i == row_len - 1);
            added = row_len;
        end
        while (added < budget)
        begin
            if ($urandom_range(7, 0) == 0)
            begin
                push_pixel(8'($urandom), 1'($urandom));
                added++;
            end
            else
            begin
                row_len = $urandom_range(16, 1);
                i = 0;
                while (i < row_len)
                begin
                    seg   = $urandom_range(6, 1);
                    trans = 1'($urandom_range(1, 0));
                    for (j = 0; j < seg && i < row_len; j++)
                    begin
                        push_pixel(trans ? stim_key : pick_literal(), i == row_len - 1);
                        i++;
                    end
                end
                added += row_len;
            end
        end
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [7:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Enable bit goes out with random upper bits, which the block ignores
    task automatic set_key(input logic en, input logic [7:0] value);
        logic [7:0] d;
        d    = 8'($urandom);
        d[0] = en;
        write_reg(CFG_KEY_ENABLE, d);
        write_reg(CFG_KEY_VALUE, value);
        stim_key_en = en;
        stim_key    = value;
    endtask

    // Block drained: all pixels taken, all words seen, pipeline settled
    task automatic wait_idle();
        while (pix_q.size() != 0 || pix_valid || exp_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Pixel driver and result stall, both changing on the falling edge
    always @(negedge clk)
    begin
        pix_item_t item;
        if (rst_n && (!pix_valid || pix_fire))
        begin
            if (pix_q.size() != 0 && $urandom_range(99, 0) >= src_idle_pct)
            begin
                item = pix_q.pop_front();
                pix_valid <= 1'b1;
                pixel     <= item.px;
                row_end   <= item.re;
            end
            else
            begin
                pix_valid <= 1'b0;
            end
        end
        res_stall <= rcv_hold || ($urandom_range(99, 0) < rcv_stall_pct);
    end

    // Monitor: track config writes, predict on pixel transactions, check words
    always @(posedge clk)
    begin
        code_word_t want;
        pix_fire <= rst_n && pix_valid && !pix_stall;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_KEY_ENABLE)
                    key_en = cfg_data[0];
                else
                    key_val = cfg_data;
                n_cfg++;
            end
            if (pix_valid && !pix_stall)
            begin
                encode_pixel(pixel, row_end);
                n_pixels++;
            end
            if (res_valid && !res_stall)
            begin
                n_words++;
                if (burst_last === 1'b1)
                    n_bursts++;
                if (exp_words.size() == 0)
                begin
                    $display("%0t: unexpected result word %h count %0d last %b",
                             $time, code_bytes, byte_count, burst_last);
                    errors++;
                end
                else
                begin
                    want = exp_words.pop_front();
                    if (code_bytes !== want.data)
                    begin
                        $display("%0t: code_bytes expected %h actual %h",
                                 $time, want.data, code_bytes);
                        errors++;
                    end
                    if (byte_count !== want.count)
                    begin
                        $display("%0t: byte_count expected %0d actual %0d",
                                 $time, want.count, byte_count);
                        errors++;
                    end
                    if (burst_last !== want.last)
                    begin
                        $display("%0t: burst_last expected %b actual %b",
                                 $time, want.last, burst_last);
                        errors++;
                    end
                end
            end
        end
    end

    // Long receiver hold-off so the block backs up into the pixel channel
    initial
    begin
        while (hold_go !== 1'b1)
            @(posedge clk);
        repeat (30) @(posedge clk);
        rcv_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rcv_hold = 1'b0;
    end

    // Watchdog on cycles without any transaction
    initial
    begin
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((pix_valid && !pix_stall) || (res_valid && !res_stall)
                || (cfg_valid && cfg_ready))
                stuck = 0;
            else
                stuck++;
        end
        $display("%0t: no transaction for %0d cycles", $time, STUCK_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // Sequence: reset, directed rows, then three random phases
    initial
    begin
        rst_n         = 1'b0;
        pix_valid     = 1'b0;
        pixel         = 8'h00;
        row_end       = 1'b0;
        res_stall     = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_KEY_ENABLE;
        cfg_data      = 8'h00;
        src_idle_pct  = 20;
        rcv_stall_pct = 48;
        rcv_hold      = 1'b0;
        hold_go       = 1'b0;
        pix_fire      = 1'b0;
        stim_key_en   = 1'b0;
        stim_key      = 8'h00;
        key_en        = 1'b0;
        key_val       = 8'h00;
        run_kind      = MODE_NONE;
        run_len       = '0;
        errors        = 0;
        n_pixels      = 0;
        n_words       = 0;
        n_bursts      = 0;
        n_cfg         = 0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // directed rows with key 0x00
        set_key(1'b1, 8'h00);
        push_pixel(8'hFF, 1'b1);        // one-pixel literal row
        push_pixel(8'h00, 1'b1);        // one-pixel transparent row
        push_pixel(8'h00, 1'b0);        // transparent run, then literal
        push_pixel(8'h00, 1'b0);
        push_pixel(8'h00, 1'b0);
        push_pixel(8'h07, 1'b0);
        push_pixel(8'h08, 1'b0);
        push_pixel(8'h09, 1'b0);
        push_pixel(8'h00, 1'b1);        // kind change on the row end pixel
        push_pixel(8'hAA, 1'b0);        // literal run spanning two words
        push_pixel(8'h55, 1'b0);
        push_pixel(8'h0F, 1'b0);
        push_pixel(8'hF0, 1'b0);
        push_pixel(8'h01, 1'b1);
        push_pixel(8'h80, 1'b0);
        push_pixel(8'h00, 1'b1);
        push_pixel(8'h00, 1'b0);        // transparent run left open
        push_pixel(8'h00, 1'b0);
        wait_idle();

        // key moves to 0xFF while a transparent run is still open
        set_key(1'b1, 8'hFF);
        push_pixel(8'h00, 1'b1);
        queue_random(170, MODE_TRANS);
        hold_go = 1'b1;
        wait_idle();

        // no key: every pixel literal, long literal run hits the limit
        src_idle_pct  = 48;
        rcv_stall_pct = 20;
        set_key(1'b0, 8'($urandom));
        queue_random(170, MODE_LIT);
        wait_idle();

        // random key, no idling on either side
        src_idle_pct  = 0;
        rcv_stall_pct = 0;
        set_key(1'b1, 8'($urandom));
        queue_random(80, MODE_NONE);
        wait_idle();

        $display("Coded %0d pixels into %0d result words (%0d bursts), %0d register writes;",
                 n_pixels, n_words, n_bursts, n_cfg);
        $display("key off, key 0x00, key 0xFF and a random key, run limit and hold-off hit.");
        if (errors == 0 && exp_words.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("%0d mismatches, %0d words still expected", errors, exp_words.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[color_key_rle_encoder.f]
+incdir+rtl
rtl/cker_pkg.sv
rtl/cker_ram.sv
rtl/cker_front.sv
rtl/cker_cmd_fifo.sv
rtl/cker_back.sv
rtl/color_key_rle_encoder.sv
verif/color_key_rle_encoder_tb.sv
